>>> src/ble_advert_id_filter_table_core_macros.svh
// Assertion helpers
`ifndef BLE_ADVERT_ID_FILTER_TABLE_CORE_MACROS_SVH
`define BLE_ADVERT_ID_FILTER_TABLE_CORE_MACROS_SVH
`define BAF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/baf_pkg.sv
`default_nettype none
package baf_pkg;
  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_TYPE = 3'd1,
    PH_LOW  = 3'd2,
    PH_HIGH = 3'd3,
    PH_SKIP = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_WRITE,
    ST_RDWAIT,
    ST_OUT
  } state_t;

  localparam logic [7:0] TYPE_UUID_INC = 8'h02;
  localparam logic [7:0] TYPE_UUID_CMP = 8'h03;
  localparam logic [7:0] TYPE_SVC_DATA = 8'h16;
  localparam logic [7:0] TYPE_MFR_DATA = 8'hFF;

  localparam int TABLE_ENTRIES = 32;
  localparam int REC_W = 74;

  typedef struct packed {
    logic [7:0]  strength;
    logic [15:0] id;
    logic [31:0] time_ms;
    logic [15:0] hits;
    logic [1:0]  kind;
  } rec_t;

  function automatic logic denied_id(input logic [15:0] id);
    return id == 16'hFD5A || id == 16'hFD69 || id == 16'h004C ||
           id == 16'h0006 || id == 16'hFEF3;
  endfunction

  function automatic logic [1:0] known_prio(input logic [15:0] id);
    logic [1:0] p;
    p = 2'd0;
    case (id)
      16'h0D53: p = 2'd3;
      16'h058E, 16'hFD5F: p = 2'd2;
      16'hFEB7, 16'hFEB8, 16'h01AB: p = 2'd1;
      default: p = 2'd0;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

>>> src/baf_in_if.sv
`default_nettype none
interface baf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  adv_byte;
  logic        last_byte;
  logic [47:0] device_mac;
  logic signed [7:0] signal_strength;
  logic [1:0]  address_kind;
  logic [31:0] time_ms;
  logic [4:0]  entry_select;
  modport source (output valid, action, adv_byte, last_byte, device_mac, signal_strength,
                  address_kind, time_ms, entry_select, input ready);
  modport sink (input valid, action, adv_byte, last_byte, device_mac, signal_strength,
                address_kind, time_ms, entry_select, output ready);
endinterface
`default_nettype wire

>>> src/baf_out_if.sv
`default_nettype none
interface baf_out_if;
  logic        valid;
  logic        ready;
  logic        is_target;
  logic [15:0] winning_id;
  logic        stored;
  logic [4:0]  slot;
  logic [5:0]  entries_used;
  logic        entry_valid;
  logic [47:0] entry_mac;
  logic signed [7:0] entry_strength;
  logic [15:0] entry_id;
  logic [31:0] entry_time;
  logic [15:0] entry_hits;
  logic [1:0]  entry_kind;
  modport source (output valid, is_target, winning_id, stored, slot, entries_used,
                  entry_valid, entry_mac, entry_strength, entry_id, entry_time,
                  entry_hits, entry_kind, input ready);
  modport sink (input valid, is_target, winning_id, stored, slot, entries_used,
                entry_valid, entry_mac, entry_strength, entry_id, entry_time,
                entry_hits, entry_kind, output ready);
endinterface
`default_nettype wire

>>> src/ble_advert_id_filter_table_core.sv
// Channel | Dir | Transaction
// in_     | in  | advert byte, clear, or read request
// out_    | out | classification result (last byte) or table entry (read)
// Advert bytes and clears give no result; a last byte without a target shows its result
// the cycle after accept. A read passes ST_RDWAIT and ST_OUT before its result shows.
// A last byte with a target scans the MAC memory one entry per cycle through its single
// read port up to a match or the fill count, then writes in ST_WRITE unless the table is full.
// Reset is synchronous; the table memories are not cleared, a fill count marks valid entries.
// in_ready is low while a result waits in the output register or a lookup or read runs.
`default_nettype none
module ble_advert_id_filter_table_core
  import baf_pkg::*;
#(
  parameter int MAX_ADVERT_BYTES = 62
) (
  input wire logic clk,
  input wire logic rst_n,
  baf_in_if.sink   in_ch,
  baf_out_if.source out_ch
);
`include "ble_advert_id_filter_table_core_macros.svh"
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int OW = $clog2(MAX_ADVERT_BYTES + 1);

  state_t st_r, st_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [7:0] left_r, left_nxt, stype_r, stype_nxt, low_r, low_nxt;
  phase_t ph_r, ph_nxt;
  logic stop_r, stop_nxt;
  logic [1:0] pf_r, pf_nxt, cf_r, cf_nxt;
  logic [17:0] pb_r, pb_nxt, cb_r, cb_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [47:0] mac_r, mac_nxt;
  rec_t newrec_r, newrec_nxt;
  logic [15:0] win_r, win_nxt;
  logic isnew_r, isnew_nxt;
  logic ov_r, ov_nxt;
  logic o_tgt_r, o_tgt_nxt, o_sto_r, o_sto_nxt, o_ev_r, o_ev_nxt;
  logic [15:0] o_win_r, o_win_nxt;
  logic [4:0] o_slot_r, o_slot_nxt;
  logic [5:0] o_used_r, o_used_nxt;
  logic [47:0] o_mac_r, o_mac_nxt;
  rec_t o_rec_r, o_rec_nxt;

  logic m_we, r_we;
  logic [AW-1:0] m_wa, m_ra, r_ra;
  logic [47:0] m_rd;
  logic [REC_W-1:0] r_rd;
  rec_t r_wd, r_rec;

  assign r_rec = rec_t'(r_rd);

  baf_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_mac (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(mac_r), .raddr(m_ra), .rdata(m_rd));
  baf_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_rec (
    .clk(clk), .we(r_we), .waddr(m_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && !ov_r;

  assign out_ch.valid = ov_r;
  assign out_ch.is_target = o_tgt_r;
  assign out_ch.winning_id = o_win_r;
  assign out_ch.stored = o_sto_r;
  assign out_ch.slot = o_slot_r;
  assign out_ch.entries_used = o_used_r;
  assign out_ch.entry_valid = o_ev_r;
  assign out_ch.entry_mac = o_mac_r;
  assign out_ch.entry_strength = o_rec_r.strength;
  assign out_ch.entry_id = o_rec_r.id;
  assign out_ch.entry_time = o_rec_r.time_ms;
  assign out_ch.entry_hits = o_rec_r.hits;
  assign out_ch.entry_kind = o_rec_r.kind;

  always_comb begin
    logic [7:0] b;
    logic [7:0] left_dec;
    logic [15:0] id;
    logic [1:0] p;
    logic [1:0] pf_t, cf_t;
    logic [17:0] pb_t, cb_t;
    b = in_ch.adv_byte;
    left_dec = left_r - 8'd1;
    id = {b, low_r};
    p = known_prio(id);
    pf_t = pf_r; pb_t = pb_r; cf_t = cf_r; cb_t = cb_r;
    st_nxt = st_r;
    off_nxt = off_r; left_nxt = left_r; stype_nxt = stype_r; low_nxt = low_r;
    ph_nxt = ph_r; stop_nxt = stop_r; pf_nxt = pf_r; pb_nxt = pb_r;
    cf_nxt = cf_r; cb_nxt = cb_r; cnt_nxt = cnt_r; idx_nxt = idx_r;
    mac_nxt = mac_r; newrec_nxt = newrec_r; win_nxt = win_r; isnew_nxt = isnew_r;
    ov_nxt = ov_r && !out_ch.ready;
    o_tgt_nxt = o_tgt_r; o_sto_nxt = o_sto_r; o_ev_nxt = o_ev_r; o_win_nxt = o_win_r;
    o_slot_nxt = o_slot_r; o_used_nxt = o_used_r; o_mac_nxt = o_mac_r; o_rec_nxt = o_rec_r;
    m_we = 1'b0; r_we = 1'b0;
    m_wa = idx_r[AW-1:0];
    m_ra = idx_r[AW-1:0];
    r_ra = idx_r[AW-1:0];
    r_wd = newrec_r;
    unique case (st_r)
      ST_IDLE: begin
        r_ra = in_ch.entry_select[AW-1:0];
        if (acc) begin
          unique case (action_t'(in_ch.action))
            ACT_CLEAR: cnt_nxt = '0;
            ACT_READ: begin
              o_tgt_nxt = 1'b0; o_win_nxt = '0; o_sto_nxt = 1'b0;
              o_slot_nxt = in_ch.entry_select;
              o_used_nxt = 6'(cnt_r);
              o_ev_nxt = (CW'(in_ch.entry_select) < cnt_r);
              idx_nxt = CW'(in_ch.entry_select);
              st_nxt = ST_RDWAIT;
            end
            ACT_BYTE: begin
              if (!stop_r && (32'(off_r) < MAX_ADVERT_BYTES)) begin
                off_nxt = off_r + OW'(1);
                if (ph_r == PH_LEN) begin
                  if (b == 8'd0) stop_nxt = 1'b1;
                  else begin left_nxt = b; ph_nxt = PH_TYPE; end
                end else begin
                  left_nxt = left_dec;
                  unique case (ph_r)
                    PH_TYPE: begin
                      stype_nxt = b;
                      ph_nxt = (b == TYPE_MFR_DATA || b == TYPE_SVC_DATA ||
                                b == TYPE_UUID_INC || b == TYPE_UUID_CMP) ? PH_LOW : PH_SKIP;
                    end
                    PH_LOW: begin low_nxt = b; ph_nxt = PH_HIGH; end
                    PH_HIGH: begin
                      if (denied_id(id)) pf_t = pf_t | 2'b10;
                      else if (p != 2'd0) begin
                        pf_t = pf_t | 2'b01;
                        if (p > pb_t[17:16]) pb_t = {p, id};
                      end
                      ph_nxt = (stype_r == TYPE_UUID_INC || stype_r == TYPE_UUID_CMP) ?
                               PH_LOW : PH_SKIP;
                    end
                    default: ;
                  endcase
                  pf_nxt = pf_t; pb_nxt = pb_t;
                  if (left_dec == 8'd0) begin
                    cf_t = cf_r | pf_t;
                    if (pb_t[17:16] > cb_r[17:16]) cb_t = pb_t;
                    cf_nxt = cf_t; cb_nxt = cb_t;
                    pf_nxt = '0; pb_nxt = '0;
                    ph_nxt = PH_LEN;
                  end
                end
              end
              if (in_ch.last_byte) begin
                off_nxt = '0; left_nxt = '0; stype_nxt = '0; low_nxt = '0;
                ph_nxt = PH_LEN; stop_nxt = 1'b0; pf_nxt = '0; pb_nxt = '0;
                cf_nxt = '0; cb_nxt = '0;
                o_win_nxt = '0; o_tgt_nxt = 1'b0; o_sto_nxt = 1'b0;
                o_slot_nxt = '0; o_ev_nxt = 1'b0; o_mac_nxt = '0; o_rec_nxt = '0;
                o_used_nxt = 6'(cnt_r);
                if (cf_t[0] && !cf_t[1]) begin
                  win_nxt = cb_t[15:0];
                  mac_nxt = in_ch.device_mac;
                  newrec_nxt.strength = in_ch.signal_strength;
                  newrec_nxt.id = cb_t[15:0];
                  newrec_nxt.time_ms = in_ch.time_ms;
                  newrec_nxt.hits = 16'd1;
                  newrec_nxt.kind = in_ch.address_kind;
                  idx_nxt = '0;
                  st_nxt = ST_SCAN;
                end else ov_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_r >= cnt_r) begin
          isnew_nxt = 1'b1;
          st_nxt = ST_WRITE;
        end else st_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (m_rd == mac_r) begin
          isnew_nxt = 1'b0;
          st_nxt = ST_WRITE;
        end else begin
          idx_nxt = idx_r + CW'(1);
          m_ra = AW'(idx_r + CW'(1));
          r_ra = AW'(idx_r + CW'(1));
          if (idx_r + CW'(1) >= cnt_r) begin
            isnew_nxt = 1'b1;
            st_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        o_tgt_nxt = 1'b1; o_win_nxt = win_r;
        if (isnew_r && (32'(cnt_r) >= TABLE_ENTRIES)) begin
          o_used_nxt = 6'(cnt_r);
        end else begin
          r_wd.hits = isnew_r ? 16'd1 :
                      ((r_rec.hits == 16'hFFFF) ? 16'hFFFF : r_rec.hits + 16'd1);
          r_we = 1'b1;
          m_we = isnew_r;
          if (isnew_r) cnt_nxt = cnt_r + CW'(1);
          o_used_nxt = 6'(isnew_r ? cnt_r + CW'(1) : cnt_r);
          o_sto_nxt = 1'b1; o_ev_nxt = 1'b1;
          o_slot_nxt = 5'(idx_r[AW-1:0]);
          o_mac_nxt = mac_r; o_rec_nxt = r_wd;
        end
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_RDWAIT: begin
        m_ra = idx_r[AW-1:0];
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (o_ev_r) begin
          o_mac_nxt = m_rd; o_rec_nxt = r_rec;
        end else begin
          o_mac_nxt = '0; o_rec_nxt = '0;
        end
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; off_r <= '0; left_r <= '0; stype_r <= '0; low_r <= '0;
      ph_r <= PH_LEN; stop_r <= 1'b0; pf_r <= '0; pb_r <= '0; cf_r <= '0; cb_r <= '0;
      cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; off_r <= off_nxt; left_r <= left_nxt; stype_r <= stype_nxt;
      low_r <= low_nxt; ph_r <= ph_nxt; stop_r <= stop_nxt; pf_r <= pf_nxt;
      pb_r <= pb_nxt; cf_r <= cf_nxt; cb_r <= cb_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    idx_r <= idx_nxt; mac_r <= mac_nxt; newrec_r <= newrec_nxt; win_r <= win_nxt;
    isnew_r <= isnew_nxt; o_tgt_r <= o_tgt_nxt; o_sto_r <= o_sto_nxt; o_ev_r <= o_ev_nxt;
    o_win_r <= o_win_nxt; o_slot_r <= o_slot_nxt; o_used_r <= o_used_nxt;
    o_mac_r <= o_mac_nxt; o_rec_r <= o_rec_nxt;
  end

  `BAF_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, 32'(cnt_r) <= TABLE_ENTRIES)
  `BAF_ASSERT_IMPL(a_busy_no_ready, clk, rst_n, st_r != ST_IDLE, !in_ch.ready)
  `BAF_ASSERT_IMPL(a_stored_target, clk, rst_n, ov_r && o_sto_r, o_tgt_r && o_ev_r)
  `BAF_ASSERT_NEXT(a_write_out, clk, rst_n, st_r == ST_WRITE, ov_r && st_r == ST_IDLE)
endmodule
`default_nettype wire

>>> src/baf_ram.sv
`default_nettype none
module baf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> bench/baf_tb_pkg.sv
package baf_tb_pkg;
  import baf_pkg::*;

  typedef struct packed {
    logic        is_target;
    logic [15:0] winning_id;
    logic        stored;
    logic [4:0]  slot;
    logic [5:0]  entries_used;
    logic        entry_valid;
    logic [47:0] entry_mac;
    logic [7:0]  entry_strength;
    logic [15:0] entry_id;
    logic [31:0] entry_time;
    logic [15:0] entry_hits;
    logic [1:0]  entry_kind;
  } sighting_t;

  localparam int TBL_DEPTH = 32;
  localparam int ADV_MAX = 62;
endpackage

>>> bench/baf_filter_checker.sv
module baf_filter_checker
  import baf_pkg::*;
  import baf_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  baf_in_if    in_ch,
  baf_out_if   out_ch,
  output int   fail_count,
  output int   pending_cnt
);
  sighting_t expected_q[$];

  logic [5:0]  offset;
  logic [7:0]  remain;
  logic [7:0]  stype;
  logic [7:0]  low_b;
  phase_t      phase;
  logic        stopped;
  logic [1:0]  p_flags, c_flags;
  logic [17:0] p_best, c_best;
  int          used;
  logic [47:0] macs[TBL_DEPTH];
  rec_t        recs[TBL_DEPTH];

  assign pending_cnt = expected_q.size();

  task automatic report(input string what, input logic [79:0] got, input logic [79:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [1:0] id_rank(input logic [15:0] id);
    case (id)
      16'h0D53: return 2'd3;
      16'h058E, 16'hFD5F: return 2'd2;
      16'hFEB7, 16'hFEB8, 16'h01AB: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  task automatic restart_parse();
    offset = 0; remain = 0; stype = 0; low_b = 0; phase = PH_LEN; stopped = 0;
    p_flags = 0; p_best = 0; c_flags = 0; c_best = 0;
  endtask

  task automatic classify_id(input logic [15:0] id);
    logic [1:0] r;
    r = id_rank(id);
    if (id == 16'hFD5A || id == 16'hFD69 || id == 16'h004C || id == 16'h0006 ||
        id == 16'hFEF3) begin
      p_flags[1] = 1'b1;
    end else if (r != 0) begin
      p_flags[0] = 1'b1;
      if (r > p_best[17:16]) p_best = {r, id};
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    if (stopped || offset >= ADV_MAX) return;
    offset++;
    if (phase == PH_LEN) begin
      if (b == 0) stopped = 1;
      else begin
        remain = b;
        phase = PH_TYPE;
      end
      return;
    end
    remain--;
    case (phase)
      PH_TYPE: begin
        stype = b;
        phase = (b == TYPE_MFR_DATA || b == TYPE_SVC_DATA || b == TYPE_UUID_INC ||
                 b == TYPE_UUID_CMP) ? PH_LOW : PH_SKIP;
      end
      PH_LOW: begin
        low_b = b;
        phase = PH_HIGH;
      end
      PH_HIGH: begin
        classify_id({b, low_b});
        phase = (stype == TYPE_UUID_INC || stype == TYPE_UUID_CMP) ? PH_LOW : PH_SKIP;
      end
      default: ;
    endcase
    if (remain == 0) begin
      c_flags |= p_flags;
      if (p_best[17:16] > c_best[17:16]) c_best = p_best;
      p_flags = 0; p_best = 0;
      phase = PH_LEN;
    end
  endtask

  function automatic sighting_t entry_view(input sighting_t s, input int k);
    sighting_t r;
    r = s;
    r.entry_valid = 1;
    r.entry_mac = macs[k];
    r.entry_strength = recs[k].strength;
    r.entry_id = recs[k].id;
    r.entry_time = recs[k].time_ms;
    r.entry_hits = recs[k].hits;
    r.entry_kind = recs[k].kind;
    return r;
  endfunction

  task automatic predict_sighting();
    sighting_t s;
    int k;
    logic hit;
    s = '0;
    hit = 0;
    if (in_ch.action == ACT_READ) begin
      s.slot = in_ch.entry_select;
      s.entries_used = 6'(used);
      if (int'(in_ch.entry_select) < used) s = entry_view(s, int'(in_ch.entry_select));
      expected_q.push_back(s);
    end else if (in_ch.action == ACT_CLEAR) begin
      used = 0;
    end else if (in_ch.action == ACT_BYTE) begin
      parse_byte(in_ch.adv_byte);
      if (in_ch.last_byte) begin
        if (c_flags == 2'b01) begin
          s.is_target = 1;
          s.winning_id = c_best[15:0];
          k = used;
          for (int i = 0; i < used; i++)
            if (!hit && macs[i] == in_ch.device_mac) begin
              k = i; hit = 1;
            end
          if (!hit && used < TBL_DEPTH) begin
            macs[k] = in_ch.device_mac;
            recs[k].hits = 0;
            used++;
            hit = 1;
          end
          if (hit) begin
            recs[k].strength = in_ch.signal_strength;
            recs[k].id = c_best[15:0];
            recs[k].time_ms = in_ch.time_ms;
            if (recs[k].hits != 16'hFFFF) recs[k].hits++;
            recs[k].kind = in_ch.address_kind;
            s.stored = 1;
            s.slot = 5'(k);
            s = entry_view(s, k);
          end
        end
        s.entries_used = 6'(used);
        restart_parse();
        expected_q.push_back(s);
      end
    end
  endtask

  task automatic compare_sighting();
    sighting_t w;
    if (expected_q.size() == 0) begin
      $display("unexpected result at %0t", $time);
      fail_count++;
      return;
    end
    w = expected_q.pop_front();
    if (out_ch.is_target !== w.is_target) report("is_target", out_ch.is_target, w.is_target);
    if (out_ch.winning_id !== w.winning_id) report("winning_id", out_ch.winning_id, w.winning_id);
    if (out_ch.stored !== w.stored) report("stored", out_ch.stored, w.stored);
    if (out_ch.slot !== w.slot) report("slot", out_ch.slot, w.slot);
    if (out_ch.entries_used !== w.entries_used)
      report("entries_used", out_ch.entries_used, w.entries_used);
    if (out_ch.entry_valid !== w.entry_valid)
      report("entry_valid", out_ch.entry_valid, w.entry_valid);
    if (out_ch.entry_mac !== w.entry_mac) report("entry_mac", out_ch.entry_mac, w.entry_mac);
    if (out_ch.entry_strength !== w.entry_strength)
      report("entry_strength", out_ch.entry_strength, w.entry_strength);
    if (out_ch.entry_id !== w.entry_id) report("entry_id", out_ch.entry_id, w.entry_id);
    if (out_ch.entry_time !== w.entry_time)
      report("entry_time", out_ch.entry_time, w.entry_time);
    if (out_ch.entry_hits !== w.entry_hits)
      report("entry_hits", out_ch.entry_hits, w.entry_hits);
    if (out_ch.entry_kind !== w.entry_kind)
      report("entry_kind", out_ch.entry_kind, w.entry_kind);
  endtask

  initial begin
    fail_count = 0;
    used = 0;
    restart_parse();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) compare_sighting();
      if (in_ch.valid && in_ch.ready) predict_sighting();
    end
  end
endmodule

>>> bench/ble_advert_id_filter_table_core_tb.sv
module ble_advert_id_filter_table_core_tb;
  import baf_pkg::*;
  import baf_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count;
  int   pending_cnt;
  int   sender_idle;
  int   sink_stall;
  int   quiet;

  baf_in_if  in_ch();
  baf_out_if out_ch();

  ble_advert_id_filter_table_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  baf_filter_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                          .fail_count(fail_count), .pending_cnt(pending_cnt));

  always #2 clk = ~clk;

  logic [47:0] mac_pool[8];
  logic [15:0] id_pool[12] = '{16'hFD5F, 16'hFEB7, 16'hFEB8, 16'h01AB, 16'h058E, 16'h0D53,
                               16'hFD5A, 16'hFD69, 16'h004C, 16'h0006, 16'hFEF3, 16'h1234};

  initial begin
    in_ch.valid = 0;
    in_ch.action = ACT_BYTE;
    in_ch.adv_byte = 0;
    in_ch.last_byte = 0;
    in_ch.device_mac = 0;
    in_ch.signal_strength = 0;
    in_ch.address_kind = 0;
    in_ch.time_ms = 0;
    in_ch.entry_select = 0;
    out_ch.ready = 0;
    sender_idle = 0;
    sink_stall = 0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || out_ch.valid && out_ch.ready) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input action_t act, input logic [7:0] b, input logic last,
                           input logic [47:0] mac, input logic [4:0] sel);
    while ($urandom_range(99) < sender_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.adv_byte <= b;
    in_ch.last_byte <= last;
    in_ch.device_mac <= mac;
    in_ch.signal_strength <= 8'($urandom);
    in_ch.address_kind <= 2'($urandom);
    in_ch.time_ms <= $urandom;
    in_ch.entry_select <= sel;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$], input logic [47:0] mac);
    foreach (bytes[i]) send_item(ACT_BYTE, bytes[i], i == bytes.size() - 1, mac, 5'($urandom));
  endtask

  task automatic read_entry(input logic [4:0] sel);
    send_item(ACT_READ, 8'($urandom), 1'($urandom), 48'({$urandom, $urandom}), sel);
  endtask

  // builds an advert from a few id-bearing or filler structures, at times truncated by one byte
  task automatic random_advert(input logic [47:0] mac);
    logic [7:0] q[$];
    logic [15:0] id;
    int n, kind, cnt;
    n = $urandom_range(1, 4);
    for (int s = 0; s < n; s++) begin
      kind = $urandom_range(0, 4);
      id = ($urandom_range(3) == 0) ? 16'($urandom) : id_pool[$urandom_range(11)];
      case (kind)
        0: begin
          cnt = $urandom_range(1, 3);
          q.push_back(8'(1 + 2 * cnt));
          q.push_back($urandom_range(1) ? TYPE_UUID_INC : TYPE_UUID_CMP);
          for (int j = 0; j < cnt; j++) begin
            id = id_pool[$urandom_range(11)];
            q.push_back(id[7:0]); q.push_back(id[15:8]);
          end
        end
        1, 2: begin
          cnt = $urandom_range(3, 6);
          q.push_back(8'(cnt));
          q.push_back(kind == 1 ? TYPE_MFR_DATA : TYPE_SVC_DATA);
          q.push_back(id[7:0]); q.push_back(id[15:8]);
          for (int j = 3; j < cnt; j++) q.push_back(8'($urandom));
        end
        3: begin
          q.push_back(8'd2); q.push_back(8'h01); q.push_back(8'($urandom));
        end
        default: begin
          cnt = $urandom_range(1, 4);
          q.push_back(8'(cnt));
          for (int j = 0; j < cnt; j++) q.push_back(8'($urandom));
        end
      endcase
    end
    if ($urandom_range(9) == 0) q.push_back(8'd0);
    if ($urandom_range(9) == 0) void'(q.pop_back());
    if (q.size() == 0) q.push_back(8'($urandom));
    send_bytes(q, mac);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(input int adverts, input int idle, input int stall);
    sender_idle = idle;
    sink_stall = stall;
    for (int a = 0; a < adverts; a++) begin
      case ($urandom_range(19))
        0: read_entry(5'($urandom));
        1: if ($urandom_range(4) == 0)
             send_item(ACT_CLEAR, 8'($urandom), 1'($urandom), 48'd0, 5'd0);
        2: send_item(ACT_NONE, 8'($urandom), 1'($urandom), 48'({$urandom, $urandom}),
                     5'($urandom));
        3: begin
          logic [7:0] q[$];
          int n;
          n = $urandom_range(1, 70);
          for (int j = 0; j < n; j++) q.push_back(8'($urandom));
          send_bytes(q, 48'({$urandom, $urandom}));
        end
        default: random_advert(($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                                         : mac_pool[$urandom_range(7)]);
      endcase
    end
    drain();
  endtask

  initial begin
    logic [7:0] q[$];
    foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = 48'h0;
    mac_pool[1] = 48'hFFFF_FFFF_FFFF;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    q = {8'h03, 8'hFF, 8'h53, 8'h0D};
    send_bytes(q, mac_pool[0]);
    q = {8'h05, 8'h03, 8'hB7, 8'hFE, 8'h8E, 8'h05, 8'h03, 8'h16, 8'h53, 8'h0D};
    send_bytes(q, mac_pool[1]);
    q = {8'h05, 8'h02, 8'h5F, 8'hFD, 8'h4C, 8'h00};
    send_bytes(q, mac_pool[2]);
    q = {8'h04, 8'h02, 8'hAB, 8'h01, 8'hFF};
    send_bytes(q, mac_pool[3]);
    q = {8'h02, 8'hFF, 8'h53, 8'h03, 8'h16, 8'hB8, 8'hFE};
    send_bytes(q, mac_pool[3]);
    q = {8'h00, 8'h03, 8'hFF, 8'h53, 8'h0D};
    send_bytes(q, mac_pool[4]);
    q = {8'h03, 8'hFF, 8'h53, 8'h0D, 8'h05, 8'h16};
    send_bytes(q, mac_pool[4]);
    q.delete();
    for (int j = 0; j < 66; j++) q.push_back(8'hFF);
    send_bytes(q, mac_pool[5]);
    read_entry(5'd0); read_entry(5'd1); read_entry(5'd5); read_entry(5'd31);
    send_item(ACT_CLEAR, 8'd0, 1'b1, 48'd0, 5'd0);
    send_item(ACT_NONE, 8'hFF, 1'b1, 48'd0, 5'd0);
    read_entry(5'd0);
    drain();

    // repeated sightings of one address
    sender_idle = 0;
    sink_stall = 0;
    q = {8'h03, 8'hFF, 8'h53, 8'h0D};
    for (int r = 0; r < 40; r++) send_bytes(q, mac_pool[6]);
    read_entry(5'd0);
    // fill the table past full
    for (int r = 0; r < 36; r++) send_bytes(q, {16'hA5A5, 32'(r)});
    read_entry(5'd31);
    drain();
    send_item(ACT_CLEAR, 8'd0, 1'b0, 48'd0, 5'd0);

    random_phase(25, 0, 0);
    random_phase(20, 81, 0);
    random_phase(20, 0, 81);
    random_phase(20, 36, 36);
    random_phase(15, $urandom_range(60), $urandom_range(60));
    for (int r = 0; r < 10; r++) send_bytes(q, {16'h5A5A, 32'($urandom)});
    random_phase(5, 0, 0);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
